@@ rtl/gauge_pie_pixel_shader_assert.svh @@
// ----------------------------------------------------------------------------
// Pie gauge pixel shader assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GAUGE_PIE_PIXEL_SHADER_ASSERT_SVH
`define GAUGE_PIE_PIXEL_SHADER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset.
`define GPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gauge pie pixel shader: same-cycle check failed");
// Next-cycle implication, checked while out of reset.
`define GPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gauge pie pixel shader: next-cycle check failed");
`else
`define GPS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/gps_pkg.sv @@
// ----------------------------------------------------------------------------
// Pie gauge pixel shader package
// Widths, class and register codes, and the quarter-wave sine table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gps_pkg;

    localparam int MAX_RADIUS         = 63;
    localparam int SCREEN_COLUMNS     = 320;
    localparam int SCREEN_ROWS        = 240;
    localparam int TRIG_FRACTION_BITS = 15;
    localparam int QUARTER_DEGREES    = 90;
    localparam int HALF_DEGREES       = 180;
    localparam int TRIG_SHIFT         = 30 - TRIG_FRACTION_BITS;

    localparam logic [63:0] Q30_ONE        = 64'd1073741824;
    localparam logic [63:0] ANGLE_STEP_Q30 = 64'd18740330;
    localparam logic [63:0] TRIG_ONE       = 64'd1 << TRIG_FRACTION_BITS;
    localparam logic [63:0] SERIES_DIVISORS [0:5] =
        '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    // Pixel classes
    localparam logic [1:0] CLASS_NONE       = 2'd0;
    localparam logic [1:0] CLASS_BACKGROUND = 2'd1;
    localparam logic [1:0] CLASS_FILL       = 2'd2;
    localparam logic [1:0] CLASS_OUTLINE    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_GAUGE_RADIUS     = 2'd0;
    localparam logic [1:0] REG_BACKGROUND_COLOR = 2'd1;
    localparam logic [1:0] REG_FILL_COLOR       = 2'd2;
    localparam logic [1:0] REG_OUTLINE_COLOR    = 2'd3;

    localparam logic [5:0]  RESET_RADIUS           = 6'd30;
    localparam logic [15:0] RESET_BACKGROUND_COLOR = 16'h7BEF;
    localparam logic [15:0] RESET_FILL_COLOR       = 16'hF800;
    localparam logic [15:0] RESET_OUTLINE_COLOR    = 16'hFFFF;

    typedef logic [TRIG_FRACTION_BITS:0] trig_t;
    typedef trig_t trig_table_t [0:QUARTER_DEGREES];

    typedef struct packed {
        logic [5:0]  gauge_radius;
        logic [15:0] background_color;
        logic [15:0] fill_color;
        logic [15:0] outline_color;
    } gps_cfg_t;

    typedef struct packed {
        logic [8:0]        center_x;
        logic [7:0]        center_y;
        logic signed [6:0] offset_x;
        logic signed [6:0] offset_y;
        logic [7:0]        fill_degrees;
    } gps_item_t;

    typedef struct packed {
        logic        write_enable;
        logic [8:0]  out_x;
        logic [7:0]  out_y;
        logic [1:0]  pixel_class;
        logic [15:0] pixel_color;
    } gps_result_t;

    // Sine of 0..90 degrees: Q30 series, rounded half up to the table precision,
    // capped at one. Evaluated at elaboration only.
    function automatic trig_table_t build_sin_table();
        trig_table_t tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        for (int k = 0; k <= QUARTER_DEGREES; k++)
        begin
            x  = 64'(k) * ANGLE_STEP_Q30;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            for (int i = 0; i < 6; i++)
            begin
                t = Q30_ONE - (((x2 * t) >> 30) / SERIES_DIVISORS[i]);
            end
            s = (x * t) >> 30;
            r = (s + (64'd1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT;
            if (r > TRIG_ONE)
            begin
                r = TRIG_ONE;
            end
            tbl[k] = r[TRIG_FRACTION_BITS:0];
        end
        return tbl;
    endfunction

    localparam trig_table_t SIN_TABLE = build_sin_table();

endpackage

@@ rtl/gauge_pie_pixel_shader.sv @@
// ----------------------------------------------------------------------------
// Pie gauge pixel shader
// Classifies one pixel of a round pie gauge and picks its color and address.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  input    | in_valid / in_stall        | center_x, center_y, offset_x,
//           |                            | offset_y, fill_degrees
//  result   | out_valid / out_stall      | write_enable, out_x, out_y,
//           |                            | pixel_class, pixel_color
//  config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
//  One word in and one word out per cycle while out_stall is low. A word
//  passes the input register, then classifier logic into the result register.
//  Reset (rst_n low, asynchronous) empties both stages and loads the default
//  radius and colors; the config port is always ready.
//  A stall on the result side freezes the result register; the input stage
//  keeps accepting until it too is full, then in_stall rises.
//
`timescale 1ns / 1ps
`include "gauge_pie_pixel_shader_assert.svh"

module gauge_pie_pixel_shader
    import gps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [8:0]  center_x,
    input  logic [7:0]  center_y,
    input  logic signed [6:0] offset_x,
    input  logic signed [6:0] offset_y,
    input  logic [7:0]  fill_degrees,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        write_enable,
    output logic [8:0]  out_x,
    output logic [7:0]  out_y,
    output logic [1:0]  pixel_class,
    output logic [15:0] pixel_color,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    gps_cfg_t    cfg_reg;
    gps_cfg_t    cfg_next;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    gps_item_t   s1_item_reg;
    gps_item_t   s1_item_next;

    logic        s2_valid_reg;
    logic        s2_valid_next;
    gps_result_t s2_result_reg;
    gps_result_t s2_result_next;

    gps_result_t result;
    logic        in_accept;
    logic        s2_load;

    // ------------------------------------------------------------------
    // Configuration registers: always ready, unknown indexes dropped
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAUGE_RADIUS:     cfg_next.gauge_radius     = cfg_data[5:0];
                REG_BACKGROUND_COLOR: cfg_next.background_color = cfg_data;
                REG_FILL_COLOR:       cfg_next.fill_color       = cfg_data;
                REG_OUTLINE_COLOR:    cfg_next.outline_color    = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gauge_radius     <= RESET_RADIUS;
            cfg_reg.background_color <= RESET_BACKGROUND_COLOR;
            cfg_reg.fill_color       <= RESET_FILL_COLOR;
            cfg_reg.outline_color    <= RESET_OUTLINE_COLOR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: advance the result stage when it is empty or being
    // drained; stall the input only when both stages hold a word.
    // ------------------------------------------------------------------
    assign s2_load   = s1_valid_reg && (!s2_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && s2_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_item_next  = s1_item_reg;
        if (in_accept)
        begin
            s1_valid_next         = 1'b1;
            s1_item_next.center_x     = center_x;
            s1_item_next.center_y     = center_y;
            s1_item_next.offset_x     = offset_x;
            s1_item_next.offset_y     = offset_y;
            s1_item_next.fill_degrees = fill_degrees;
        end
        else if (s2_load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        s2_valid_next  = s2_valid_reg;
        s2_result_next = s2_result_reg;
        if (s2_load)
        begin
            s2_valid_next  = 1'b1;
            s2_result_next = result;
        end
        else if (!out_stall)
        begin
            s2_valid_next = 1'b0;
        end
    end

    // Control bits reset; payload holds whatever it had
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg   <= s1_item_next;
        s2_result_reg <= s2_result_next;
    end

    // ------------------------------------------------------------------
    // Classification between the two registers
    // ------------------------------------------------------------------
    gps_classifier u_classifier
    (
        .item   (s1_item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign out_valid    = s2_valid_reg;
    assign write_enable = s2_result_reg.write_enable;
    assign out_x        = s2_result_reg.out_x;
    assign out_y        = s2_result_reg.out_y;
    assign pixel_class  = s2_result_reg.pixel_class;
    assign pixel_color  = s2_result_reg.pixel_color;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `GPS_ASSERT_IMPL(a_stall_only_when_full, clk, rst_n, in_stall,
        s1_valid_reg && s2_valid_reg)
    `GPS_ASSERT_NEXT(a_input_word_held, clk, rst_n, s1_valid_reg && !s2_load,
        s1_valid_reg)
    `GPS_ASSERT_IMPL(a_write_needs_class, clk, rst_n, out_valid && write_enable,
        pixel_class != CLASS_NONE)
    `GPS_ASSERT_IMPL(a_write_on_screen, clk, rst_n, out_valid && write_enable,
        (out_x < 9'(SCREEN_COLUMNS)) && (out_y < 8'(SCREEN_ROWS)))
    `GPS_ASSERT_IMPL(a_none_is_blank, clk, rst_n,
        out_valid && (pixel_class == CLASS_NONE),
        (pixel_color == 16'h0000) && !write_enable)

endmodule

@@ rtl/gps_classifier.sv @@
// ----------------------------------------------------------------------------
// Pie gauge pixel classifier
// Outline, fill, background or none for one pixel, plus its screen address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gps_classifier
    import gps_pkg::*;
(
    input  gps_item_t   item,
    input  gps_cfg_t    cfg,
    output gps_result_t result
);

    logic [5:0]         radius;
    logic [7:0]         fill_clamped;
    logic [6:0]         adx;
    logic [6:0]         ady;
    logic [12:0]        dx_sq;
    logic [12:0]        dy_sq;
    logic [11:0]        r_sq;
    logic [11:0]        remain;
    logic [15:0]        four_remain;
    logic [7:0]         lo;
    logic [7:0]         hi;
    logic [15:0]        lo_sq;
    logic [15:0]        hi_sq;
    logic               on_outline;
    logic               in_disc;
    logic               in_half;
    logic               upper_quadrant;
    logic [6:0]         sin_index;
    logic [6:0]         cos_index;
    logic signed [17:0] sin_val;
    logic signed [17:0] cos_val;
    logic signed [24:0] prod_s;
    logic signed [24:0] prod_c;
    logic signed [25:0] cross_term;
    logic               in_slice;
    logic [1:0]         cls;
    logic [15:0]        color;
    logic signed [10:0] px;
    logic signed [9:0]  py;
    logic               on_screen;

    // The 6-bit radius never exceeds MAX_RADIUS, so no clamp is needed.
    assign radius       = cfg.gauge_radius;
    assign fill_clamped = (item.fill_degrees > 8'(HALF_DEGREES)) ? 8'(HALF_DEGREES)
                                                                  : item.fill_degrees;

    assign adx = item.offset_x[6] ? 7'(-item.offset_x) : 7'(item.offset_x);
    assign ady = item.offset_y[6] ? 7'(-item.offset_y) : 7'(item.offset_y);

    assign dx_sq = 13'(adx * adx);
    assign dy_sq = 13'(ady * ady);
    assign r_sq  = 12'(radius * radius);

    // Outline: |dy| is the rounded chord height, checked on doubled values
    assign remain      = r_sq - dx_sq[11:0];
    assign four_remain = {2'b00, remain, 2'b00};
    assign lo          = {ady, 1'b0} - 8'd1;
    assign hi          = {ady, 1'b0} + 8'd1;
    assign lo_sq       = 16'(lo * lo);
    assign hi_sq       = 16'(hi * hi);

    always_comb
    begin
        on_outline = 1'b0;
        if ({1'b0, adx} <= {2'b00, radius})
        begin
            if (ady == 7'd0)
            begin
                on_outline = (remain == 12'd0);
            end
            else
            begin
                on_outline = (lo_sq <= four_remain) && (four_remain < hi_sq);
            end
        end
    end

    assign in_disc = ({1'b0, dx_sq} + {1'b0, dy_sq}) <= {2'b00, r_sq};
    assign in_half = (!item.offset_y[6] && (item.offset_y != 7'sd0)) ||
                     ((item.offset_y == 7'sd0) && !item.offset_x[6] &&
                      (item.offset_x != 7'sd0));

    // Fold the fill angle onto the quarter-wave table
    assign upper_quadrant = fill_clamped > 8'(QUARTER_DEGREES);
    assign sin_index = upper_quadrant ? 7'(8'(HALF_DEGREES) - fill_clamped)
                                      : fill_clamped[6:0];
    assign cos_index = upper_quadrant ? 7'(fill_clamped - 8'(QUARTER_DEGREES))
                                      : 7'(8'(QUARTER_DEGREES) - fill_clamped);
    assign sin_val = $signed({2'b00, SIN_TABLE[sin_index]});
    assign cos_val = upper_quadrant ? -$signed({2'b00, SIN_TABLE[cos_index]})
                                    :  $signed({2'b00, SIN_TABLE[cos_index]});

    assign prod_s     = 25'(item.offset_x) * 25'(sin_val);
    assign prod_c     = 25'(item.offset_y) * 25'(cos_val);
    assign cross_term = 26'(prod_s) - 26'(prod_c);
    assign in_slice   = !cross_term[25];

    always_comb
    begin
        if (on_outline)
        begin
            cls   = CLASS_OUTLINE;
            color = cfg.outline_color;
        end
        else if (in_disc && in_half && in_slice)
        begin
            cls   = CLASS_FILL;
            color = cfg.fill_color;
        end
        else if (in_disc)
        begin
            cls   = CLASS_BACKGROUND;
            color = cfg.background_color;
        end
        else
        begin
            cls   = CLASS_NONE;
            color = 16'h0000;
        end
    end

    assign px = $signed({2'b00, item.center_x}) + 11'(item.offset_x);
    assign py = $signed({2'b00, item.center_y}) + 10'(item.offset_y);
    assign on_screen = !px[10] && (px[9:0] < 10'(SCREEN_COLUMNS)) &&
                       !py[9]  && (py[8:0] < 9'(SCREEN_ROWS));

    always_comb
    begin
        result.pixel_class  = cls;
        result.pixel_color  = color;
        result.write_enable = (cls != CLASS_NONE) && on_screen;
        result.out_x        = result.write_enable ? px[8:0] : 9'd0;
        result.out_y        = result.write_enable ? py[7:0] : 8'd0;
    end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Pie gauge pixel shader testbench
// Streams pixel offsets through the shader under random input gaps and
// result stalls, predicts the untabulated words from a local copy of the
// gauge registers, and compares each result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import gps_pkg::*;

    // Terms of the sine series, innermost first
    localparam logic [63:0] TERM_DIVISORS [0:5] =
        '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    localparam int PHASE_COUNT      = 8;
    localparam int PIXELS_PER_PHASE = 225;
    localparam int DRAIN_CYCLES     = 8;

    // One row of the directed table: the pixel, and where the answer is
    // obvious, the word that must come back for it
    typedef struct {
        gps_item_t   pixel;
        bit          typed;
        gps_result_t want;
    } pixel_case_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [8:0]  center_x = '0;
    logic [7:0]  center_y = '0;
    logic signed [6:0] offset_x = '0;
    logic signed [6:0] offset_y = '0;
    logic [7:0]  fill_degrees = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        write_enable;
    logic [8:0]  out_x;
    logic [7:0]  out_y;
    logic [1:0]  pixel_class;
    logic [15:0] pixel_color;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Local copy of the gauge registers and the sine table in Q15
    gps_cfg_t    live_registers;
    longint      sine_q15 [0:QUARTER_DEGREES];

    // Classifications still owed by the shader, oldest first
    gps_result_t pending_pixels [$];

    int          mismatches = 0;
    int          pixels_sent = 0;
    int          words_seen = 0;
    int          offscreen_seen = 0;
    int          register_writes = 0;
    int          class_seen [0:3] = '{0, 0, 0, 0};

    int          stall_mode = 0;
    int          stall_left = 0;

    // Extremes, every class, the fill angle clamp, the center pixel and
    // off-screen pixels, all under the reset registers (radius 30)
    pixel_case_t directed_cases [0:24] = '{
        // center pixel: never fill, drawn as background
        '{'{9'd100, 8'd100, 7'sd0, 7'sd0, 8'd90}, 1'b1,
          '{1'b1, 9'd100, 8'd100, CLASS_BACKGROUND, 16'h7BEF}},
        // outline on the four axes
        '{'{9'd100, 8'd100, 7'sd30, 7'sd0, 8'd90}, 1'b1,
          '{1'b1, 9'd130, 8'd100, CLASS_OUTLINE, 16'hFFFF}},
        '{'{9'd100, 8'd100, 7'sd0, 7'sd30, 8'd90}, 1'b1,
          '{1'b1, 9'd100, 8'd130, CLASS_OUTLINE, 16'hFFFF}},
        '{'{9'd100, 8'd100, -7'sd30, 7'sd0, 8'd90}, 1'b1,
          '{1'b1, 9'd70, 8'd100, CLASS_OUTLINE, 16'hFFFF}},
        '{'{9'd100, 8'd100, 7'sd0, -7'sd30, 8'd0}, 1'b1,
          '{1'b1, 9'd100, 8'd70, CLASS_OUTLINE, 16'hFFFF}},
        // offset corners, well outside the disc
        '{'{9'd100, 8'd100, -7'sd63, -7'sd63, 8'd90}, 1'b1,
          '{1'b0, 9'd0, 8'd0, CLASS_NONE, 16'h0000}},
        '{'{9'd100, 8'd100, 7'sd63, 7'sd63, 8'd255}, 1'b1,
          '{1'b0, 9'd0, 8'd0, CLASS_NONE, 16'h0000}},
        // most negative offset the field can carry
        '{'{9'd100, 8'd100, 7'sh40, 7'sh40, 8'd0}, 1'b1,
          '{1'b0, 9'd0, 8'd0, CLASS_NONE, 16'h0000}},
        // zero fill angle: the positive x axis is filled, straight down is not
        '{'{9'd100, 8'd100, 7'sd10, 7'sd0, 8'd0}, 1'b1,
          '{1'b1, 9'd110, 8'd100, CLASS_FILL, 16'hF800}},
        '{'{9'd100, 8'd100, 7'sd0, 7'sd10, 8'd0}, 1'b1,
          '{1'b1, 9'd100, 8'd110, CLASS_BACKGROUND, 16'h7BEF}},
        // angle above 180 clamps to a full half disc
        '{'{9'd100, 8'd100, 7'sd0, 7'sd10, 8'd255}, 1'b1,
          '{1'b1, 9'd100, 8'd110, CLASS_FILL, 16'hF800}},
        // negative x axis lies outside the fill half plane
        '{'{9'd100, 8'd100, -7'sd10, 7'sd0, 8'd200}, 1'b1,
          '{1'b1, 9'd90, 8'd100, CLASS_BACKGROUND, 16'h7BEF}},
        '{'{9'd100, 8'd100, -7'sd10, 7'sd1, 8'd180}, 1'b1,
          '{1'b1, 9'd90, 8'd101, CLASS_FILL, 16'hF800}},
        // off screen: no write, address zero, class still reported
        '{'{9'd0, 8'd0, -7'sd5, -7'sd5, 8'd90}, 1'b1,
          '{1'b0, 9'd0, 8'd0, CLASS_BACKGROUND, 16'h7BEF}},
        '{'{9'd319, 8'd239, 7'sd1, 7'sd0, 8'd90}, 1'b1,
          '{1'b0, 9'd0, 8'd0, CLASS_FILL, 16'hF800}},
        '{'{9'd511, 8'd255, 7'sd0, 7'sd0, 8'd0}, 1'b1,
          '{1'b0, 9'd0, 8'd0, CLASS_BACKGROUND, 16'h7BEF}},
        // screen corners, on screen
        '{'{9'd319, 8'd239, 7'sd0, 7'sd0, 8'd181}, 1'b1,
          '{1'b1, 9'd319, 8'd239, CLASS_BACKGROUND, 16'h7BEF}},
        '{'{9'd0, 8'd0, 7'sd0, 7'sd0, 8'd0}, 1'b1,
          '{1'b1, 9'd0, 8'd0, CLASS_BACKGROUND, 16'h7BEF}},
        // pixels near the fill edge and the outline
        '{'{9'd160, 8'd120, 7'sd20, 7'sd20, 8'd45}, 1'b0, '0},
        '{'{9'd160, 8'd120, -7'sd20, 7'sd15, 8'd135}, 1'b0, '0},
        '{'{9'd160, 8'd120, 7'sd15, -7'sd20, 8'd90}, 1'b0, '0},
        '{'{9'd160, 8'd120, 7'sd21, 7'sd21, 8'd44}, 1'b0, '0},
        '{'{9'd160, 8'd120, -7'sd21, 7'sd21, 8'd136}, 1'b0, '0},
        '{'{9'd160, 8'd120, 7'sd7, 7'sd29, 8'd76}, 1'b0, '0},
        '{'{9'd255, 8'd128, -7'sd25, 7'sd17, 8'd128}, 1'b0, '0}
    };

    gauge_pie_pixel_shader u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .center_x     (center_x),
        .center_y     (center_y),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .fill_degrees (fill_degrees),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_enable (write_enable),
        .out_x        (out_x),
        .out_y        (out_y),
        .pixel_class  (pixel_class),
        .pixel_color  (pixel_color),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Tabulate sin(0..90 deg): Q30 series, round half up to Q15, cap at one
    initial
    begin
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        for (int k = 0; k <= QUARTER_DEGREES; k++)
        begin
            x  = 64'(k) * ANGLE_STEP_Q30;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            foreach (TERM_DIVISORS[i])
            begin
                t = Q30_ONE - (((x2 * t) >> 30) / TERM_DIVISORS[i]);
            end
            s = (((x * t) >> 30) + (64'd1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT;
            sine_q15[k] = (s > TRIG_ONE) ? longint'(TRIG_ONE) : longint'(s);
        end
    end

    // Work out the word the shader owes for one pixel under the live registers
    function automatic gps_result_t classify_pixel(gps_item_t px);
        longint      dx;
        longint      dy;
        longint      r;
        longint      adx;
        longint      ady;
        longint      span;
        longint      lo;
        longint      hi;
        longint      s;
        longint      c;
        longint      sx;
        longint      sy;
        int          angle;
        logic [1:0]  cls;
        gps_result_t res;
        dx    = longint'($signed(px.offset_x));
        dy    = longint'($signed(px.offset_y));
        r     = longint'(live_registers.gauge_radius);
        angle = int'(px.fill_degrees);
        if (r > MAX_RADIUS)
        begin
            r = MAX_RADIUS;
        end
        if (angle > HALF_DEGREES)
        begin
            angle = HALF_DEGREES;
        end
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        cls = CLASS_NONE;

        // Outline: |dy| is the rounded circle height at dx, tested with squares
        if (adx <= r)
        begin
            span = r * r - dx * dx;
            if (ady == 0)
            begin
                if (span == 0)
                begin
                    cls = CLASS_OUTLINE;
                end
            end
            else
            begin
                lo = 2 * ady - 1;
                hi = 2 * ady + 1;
                if (lo * lo <= 4 * span && 4 * span < hi * hi)
                begin
                    cls = CLASS_OUTLINE;
                end
            end
        end

        // Disc interior: fill where the cross product against the fill
        // direction is not negative, in the lower half plane only
        if (cls == CLASS_NONE && dx * dx + dy * dy <= r * r)
        begin
            cls = CLASS_BACKGROUND;
            if (dy > 0 || (dy == 0 && dx > 0))
            begin
                if (angle <= QUARTER_DEGREES)
                begin
                    s = sine_q15[angle];
                    c = sine_q15[QUARTER_DEGREES - angle];
                end
                else
                begin
                    s = sine_q15[HALF_DEGREES - angle];
                    c = -sine_q15[angle - QUARTER_DEGREES];
                end
                if (dx * s - dy * c >= 0)
                begin
                    cls = CLASS_FILL;
                end
            end
        end

        res = '0;
        res.pixel_class = cls;
        case (cls)
            CLASS_OUTLINE:    res.pixel_color = live_registers.outline_color;
            CLASS_FILL:       res.pixel_color = live_registers.fill_color;
            CLASS_BACKGROUND: res.pixel_color = live_registers.background_color;
            default:          res.pixel_color = '0;
        endcase

        sx = longint'(px.center_x) + dx;
        sy = longint'(px.center_y) + dy;
        if (cls != CLASS_NONE && sx >= 0 && sx < SCREEN_COLUMNS && sy >= 0 && sy < SCREEN_ROWS)
        begin
            res.write_enable = 1'b1;
            res.out_x        = sx[8:0];
            res.out_y        = sy[7:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t word %0d: %s", $time, words_seen, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        end
    endtask

    // Present one pixel at the falling edge and hold it until it is taken;
    // queue the word it owes at the edge that takes it
    task automatic send_pixel(input gps_item_t px, input bit typed,
                              input gps_result_t typed_want);
        @(negedge clk);
        center_x     = px.center_x;
        center_y     = px.center_y;
        offset_x     = px.offset_x;
        offset_y     = px.offset_y;
        fill_degrees = px.fill_degrees;
        in_valid     = 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_pixels.push_back(typed ? typed_want : classify_pixel(px));
        pixels_sent++;
    endtask

    task automatic idle_input(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    // Drop valid and hold off until every owed word has come back
    task automatic drain_pixels();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Write all four registers back to back, then release the port
    task automatic program_registers(input gps_cfg_t plan);
        logic [15:0] values [0:3];
        values[REG_GAUGE_RADIUS]     = {10'($urandom), plan.gauge_radius};
        values[REG_BACKGROUND_COLOR] = plan.background_color;
        values[REG_FILL_COLOR]       = plan.fill_color;
        values[REG_OUTLINE_COLOR]    = plan.outline_color;
        for (int idx = 0; idx < 4; idx++)
        begin
            @(negedge clk);
            cfg_valid = 1'b1;
            cfg_index = 2'(idx);
            cfg_data  = values[idx];
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            case (2'(idx))
                REG_GAUGE_RADIUS:     live_registers.gauge_radius = values[idx][5:0];
                REG_BACKGROUND_COLOR: live_registers.background_color = values[idx];
                REG_FILL_COLOR:       live_registers.fill_color = values[idx];
                default:              live_registers.outline_color = values[idx];
            endcase
            register_writes++;
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random pixels in bursts: most offsets land in a box around the disc so
    // outline, fill and background all show up; the rest span the whole field
    task automatic run_random_phase(input int count);
        int        left;
        int        burst;
        int        reach;
        int        dx;
        int        dy;
        gps_item_t px;
        left  = count;
        reach = int'(live_registers.gauge_radius) + 2;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left)
            begin
                burst = left;
            end
            repeat (burst)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    dx = $urandom_range(0, 2 * reach) - reach;
                    dy = $urandom_range(0, 2 * reach) - reach;
                    dx = (dx < -64) ? -64 : ((dx > 63) ? 63 : dx);
                    dy = (dy < -64) ? -64 : ((dy > 63) ? 63 : dy);
                end
                else
                begin
                    dx = $urandom_range(0, 127);
                    dy = $urandom_range(0, 127);
                end
                px.offset_x = 7'(dx);
                px.offset_y = 7'(dy);
                case ($urandom_range(0, 19))
                    0, 1:
                    begin
                        px.center_x = 9'($urandom_range(0, 511));
                        px.center_y = 8'($urandom_range(0, 255));
                    end
                    2, 3, 4:
                    begin
                        // hug a screen edge so the disc spills off
                        px.center_x = $urandom_range(0, 1) ? 9'($urandom_range(0, 70))
                                                           : 9'($urandom_range(250, 319));
                        px.center_y = $urandom_range(0, 1) ? 8'($urandom_range(0, 70))
                                                           : 8'($urandom_range(170, 239));
                    end
                    default:
                    begin
                        px.center_x = 9'($urandom_range(0, SCREEN_COLUMNS - 1));
                        px.center_y = 8'($urandom_range(0, SCREEN_ROWS - 1));
                    end
                endcase
                px.fill_degrees = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(181, 255))
                                                              : 8'($urandom_range(0, 180));
                send_pixel(px, 1'b0, '0);
            end
            left -= burst;
            // most bursts end in a gap, some run straight into the next one
            if ($urandom_range(0, 3) != 0)
            begin
                idle_input($urandom_range(1, 8));
            end
        end
    endtask

    // Result side stall: switch pattern at random between free
    // flow, light and heavy random stalls, and a regular on/off beat
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall = 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            else
            begin
                stall_left--;
            end
            case (stall_mode)
                0:       out_stall = 1'b0;
                1:       out_stall = ($urandom_range(0, 3) == 0);
                2:       out_stall = ($urandom_range(0, 9) < 7);
                default: out_stall = ((stall_left / 8) % 2 == 1);
            endcase
        end
    end

    // Take each result word at the rising edge and hold it against the
    // oldest owed classification
    always @(posedge clk)
    begin
        gps_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                report_mismatch($sformatf("word with nothing owed, class %0d color 0x%0h",
                                          pixel_class, pixel_color));
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("write_enable", 16'(write_enable), 16'(want.write_enable));
                check_field("out_x", 16'(out_x), 16'(want.out_x));
                check_field("out_y", 16'(out_y), 16'(want.out_y));
                check_field("pixel_class", 16'(pixel_class), 16'(want.pixel_class));
                check_field("pixel_color", pixel_color, want.pixel_color);
                class_seen[want.pixel_class]++;
                if (want.pixel_class != CLASS_NONE && !want.write_enable)
                begin
                    offscreen_seen++;
                end
            end
            words_seen++;
        end
    end

    // Stimulus: directed table under reset registers, then random phases,
    // each one after a full drain and a fresh set of registers
    initial
    begin
        gps_cfg_t plan;
        live_registers = '{RESET_RADIUS, RESET_BACKGROUND_COLOR, RESET_FILL_COLOR,
                           RESET_OUTLINE_COLOR};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_cases[i])
        begin
            send_pixel(directed_cases[i].pixel, directed_cases[i].typed,
                       directed_cases[i].want);
            if ($urandom_range(0, 2) == 0)
            begin
                idle_input($urandom_range(1, 3));
            end
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: plan = '{6'd63, 16'h0000, 16'hFFFF, 16'h0000};
                1: plan = '{6'd1, 16'hFFFF, 16'h0000, 16'($urandom)};
                // zero radius leaves only the center pixel, as outline
                2: plan = '{6'd0, 16'($urandom), 16'($urandom), 16'($urandom)};
                3: plan = '{6'd2, 16'($urandom), 16'($urandom), 16'($urandom)};
                default: plan = '{6'($urandom_range(1, MAX_RADIUS)), 16'($urandom),
                                  16'($urandom), 16'($urandom)};
            endcase
            // registers move only with the pipeline empty
            drain_pixels();
            program_registers(plan);
            run_random_phase(PIXELS_PER_PHASE);
        end

        drain_pixels();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixels over %0d register settings (%0d register writes)",
                 pixels_sent, PHASE_COUNT + 1, register_writes);
        $display("Classes seen: %0d outline, %0d fill, %0d background, %0d empty; %0d off screen",
                 class_seen[CLASS_OUTLINE], class_seen[CLASS_FILL],
                 class_seen[CLASS_BACKGROUND], class_seen[CLASS_NONE], offscreen_seen);
        if (mismatches == 0 && pending_pixels.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hang guard: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d words still owed", pending_pixels.size());
        $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/gps_pkg.sv
rtl/gps_classifier.sv
rtl/gauge_pie_pixel_shader.sv
tb/sv/tb_top.sv
